// ===== rtl/cds_pkg.sv =====
// Shared types, constants and month-length helper for the calendar date stepper.
package cds_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_LIMIT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_CHK  = 2'd2,
    S_STEP = 2'd3
  } state_e;

  localparam logic [13:0] YearMin   = 14'd1;
  localparam logic [13:0] YearMax   = 14'd9999;
  localparam logic [13:0] YearReset = 14'd2000;
  localparam logic [6:0]  CenReset  = 7'd20;
  localparam logic [6:0]  YyReset   = 7'd0;
  localparam logic [6:0]  YyLast    = 7'd99;

  // floor(y / 100) == (y * Div100Mul) >> Div100Shift for every 14-bit y
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] d;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      default:                                    d = leap ? 5'd29 : 5'd28;
    endcase
    return d;
  endfunction

  // leap from century / year-of-century split
  function automatic logic leap_of(input logic [6:0] cen, input logic [6:0] yy);
    return (yy != 7'd0) ? (yy[1:0] == 2'b00) : (cen[1:0] == 2'b00);
  endfunction

endpackage

// ===== rtl/calendar_date_stepper_unit.sv =====
// Gregorian date register with load, add-days and subtract-days commands.
//
//  channel  | ports                                          | dir | handshake
//  ---------+------------------------------------------------+-----+--------------------
//  command  | command_i, load_day_i, load_month_i,           | in  | start & !busy
//           | load_year_i, day_count_i                       |     |
//  result   | cur_day_o, cur_month_o, cur_year_o,            | out | done_o, one cycle
//           | leap_flag_o, status_o                          |     |
//
// Sequence: a load goes through S_DIV, which registers the divide-by-100
//   quotient of the year, then S_CHK, which checks the date.
//   Add/subtract runs in S_STEP: one shared day-step unit moves the
//   date by one day per cycle until S_STEP sees the count exhausted.
//   An early stop at a range limit ends the item at once. Command 3 reports the date.
// Reset: date is 2000-01-01, sequencer idle, no result pending.
// Stalls: busy is high while an item is in work; done_o is a one-cycle
//   strobe that cannot be held off, and a new item may be accepted in it.
module calendar_date_stepper_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [4:0]  load_day_i,
  input  logic [3:0]  load_month_i,
  input  logic [13:0] load_year_i,
  input  logic [15:0] day_count_i,
  output logic        done_o,
  output logic [4:0]  cur_day_o,
  output logic [3:0]  cur_month_o,
  output logic [13:0] cur_year_o,
  output logic        leap_flag_o,
  output logic [1:0]  status_o
);

  // only the low COUNT_BITS bits (at most 16) of the 16-bit count are used
  localparam int unsigned CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  cds_pkg::state_e  state_q, state_d;
  cds_pkg::cmd_e    cmd_q, cmd_d;
  cds_pkg::status_e status_q, status_d;
  logic             done_q, done_d;

  // date held both as binary year and as century / year-of-century
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  cen_q, cen_d;
  logic [6:0]  yy_q, yy_d;

  // per-item work registers
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [4:0]      ld_q, ld_d;
  logic [3:0]      lm_q, lm_d;
  logic [13:0]     ly_q, ly_d;
  logic [7:0]      q_q, q_d;

  logic        accept;
  logic        leap_cur;
  logic [26:0] div_prod;
  logic [14:0] q_times100;
  logic [14:0] lo_full;
  logic [6:0]  ld_lo;
  logic        ld_leap;
  logic        ld_ok;

  assign accept   = start && !busy;
  assign busy     = (state_q != cds_pkg::S_IDLE);
  assign leap_cur = cds_pkg::leap_of(cen_q, yy_q);

  // load path: one multiply registered, then remainder by shift-add
  assign div_prod   = {13'd0, ly_q} * {14'd0, cds_pkg::Div100Mul};
  assign q_times100 = ({7'd0, q_q} << 6) + ({7'd0, q_q} << 5) + ({7'd0, q_q} << 2);
  assign lo_full    = {1'b0, ly_q} - q_times100;
  assign ld_lo      = lo_full[6:0];
  assign ld_leap    = (ld_lo != 7'd0) ? (ld_lo[1:0] == 2'b00) : (q_q[1:0] == 2'b00);
  assign ld_ok      = (ly_q >= cds_pkg::YearMin) && (ly_q <= cds_pkg::YearMax)
                   && (lm_q >= 4'd1) && (lm_q <= 4'd12)
                   && (ld_q >= 5'd1) && (ld_q <= cds_pkg::days_in(lm_q, ld_leap));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cds_pkg::S_IDLE;
      cmd_q    <= cds_pkg::CMD_NONE;
      status_q <= cds_pkg::ST_OK;
      done_q   <= 1'b0;
      day_q    <= 5'd1;
      month_q  <= 4'd1;
      year_q   <= cds_pkg::YearReset;
      cen_q    <= cds_pkg::CenReset;
      yy_q     <= cds_pkg::YyReset;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
      done_q   <= done_d;
      day_q    <= day_d;
      month_q  <= month_d;
      year_q   <= year_d;
      cen_q    <= cen_d;
      yy_q     <= yy_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d;
    lm_q <= lm_d;
    ly_q <= ly_d;
    q_q  <= q_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    status_d = status_q;
    done_d   = 1'b0;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    cen_d    = cen_q;
    yy_d     = yy_q;
    cnt_d    = cnt_q;
    ld_d     = ld_q;
    lm_d     = lm_q;
    ly_d     = ly_q;
    q_d      = q_q;

    unique case (state_q)
      cds_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d = cds_pkg::cmd_e'(command_i);
          ld_d  = load_day_i;
          lm_d  = load_month_i;
          ly_d  = load_year_i;
          cnt_d = day_count_i[CntW-1:0];
          unique case (cds_pkg::cmd_e'(command_i))
            cds_pkg::CMD_LOAD: state_d = cds_pkg::S_DIV;
            cds_pkg::CMD_ADD,
            cds_pkg::CMD_SUB:  state_d = cds_pkg::S_STEP;
            default: begin
              // unused command: report current date
              status_d = cds_pkg::ST_OK;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      cds_pkg::S_DIV: begin
        q_d     = div_prod[cds_pkg::Div100Shift +: 8];
        state_d = cds_pkg::S_CHK;
      end

      cds_pkg::S_CHK: begin
        if (ld_ok) begin
          day_d    = ld_q;
          month_d  = lm_q;
          year_d   = ly_q;
          cen_d    = q_q[6:0];
          yy_d     = ld_lo;
          status_d = cds_pkg::ST_OK;
        end else begin
          status_d = cds_pkg::ST_BAD_LOAD;
        end
        done_d  = 1'b1;
        state_d = cds_pkg::S_IDLE;
      end

      cds_pkg::S_STEP: begin
        if (cnt_q == '0) begin
          status_d = cds_pkg::ST_OK;
          done_d   = 1'b1;
          state_d  = cds_pkg::S_IDLE;
        end else if (cmd_q == cds_pkg::CMD_ADD) begin
          if (day_q == 5'd31 && month_q == 4'd12) begin
            if (year_q >= cds_pkg::YearMax) begin
              status_d = cds_pkg::ST_LIMIT;
              done_d   = 1'b1;
              state_d  = cds_pkg::S_IDLE;
            end else begin
              year_d  = year_q + 14'd1;
              day_d   = 5'd1;
              month_d = 4'd1;
              if (yy_q == cds_pkg::YyLast) begin
                yy_d  = 7'd0;
                cen_d = cen_q + 7'd1;
              end else begin
                yy_d = yy_q + 7'd1;
              end
              cnt_d = cnt_q - CntW'(1);
            end
          end else if (day_q >= cds_pkg::days_in(month_q, leap_cur)) begin
            month_d = month_q + 4'd1;
            day_d   = 5'd1;
            cnt_d   = cnt_q - CntW'(1);
          end else begin
            day_d = day_q + 5'd1;
            cnt_d = cnt_q - CntW'(1);
          end
        end else begin
          if (day_q == 5'd1 && month_q == 4'd1) begin
            if (year_q <= cds_pkg::YearMin) begin
              status_d = cds_pkg::ST_LIMIT;
              done_d   = 1'b1;
              state_d  = cds_pkg::S_IDLE;
            end else begin
              year_d  = year_q - 14'd1;
              day_d   = 5'd31;
              month_d = 4'd12;
              if (yy_q == 7'd0) begin
                yy_d  = cds_pkg::YyLast;
                cen_d = cen_q - 7'd1;
              end else begin
                yy_d = yy_q - 7'd1;
              end
              cnt_d = cnt_q - CntW'(1);
            end
          end else if (day_q == 5'd1) begin
            month_d = month_q - 4'd1;
            day_d   = cds_pkg::days_in(month_q - 4'd1, leap_cur);
            cnt_d   = cnt_q - CntW'(1);
          end else begin
            day_d = day_q - 5'd1;
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end

      default: state_d = cds_pkg::S_IDLE;
    endcase
  end

  assign done_o      = done_q;
  assign cur_day_o   = day_q;
  assign cur_month_o = month_q;
  assign cur_year_o  = year_q;
  assign leap_flag_o = leap_cur;
  assign status_o    = status_q;

  // the result strobe only fires once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // the load divide step always hands over to the check step
  a_div_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::S_DIV) |=> (state_q == cds_pkg::S_CHK))
    else $error("load sequence broken");

  // held date is always a real calendar day
  a_date_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q >= 5'd1) && (day_q <= cds_pkg::days_in(month_q, leap_cur))
    && (month_q >= 4'd1) && (month_q <= 4'd12))
    else $error("held date invalid");

  // century split tracks the binary year
  a_year_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({7'd0, cen_q} * 14'd100 + {7'd0, yy_q}) == year_q)
    else $error("century split out of step with year");

endmodule

// ===== test/calendar_date_stepper_unit_tb.sv =====
// Self-checking testbench for the calendar date stepper: directed table plus random commands.
`timescale 1ns / 1ps

module calendar_date_stepper_unit_tb;

  // One command item as driven on the input ports.
  typedef struct packed {
    cds_pkg::cmd_e cmd;
    logic [4:0]    day;
    logic [3:0]    month;
    logic [13:0]   year;
    logic [15:0]   count;
  } cmd_item_t;

  // One result item as seen on the output ports.
  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [13:0]      year;
    logic             leap;
    cds_pkg::status_e status;
  } date_result_t;

  // Directed row: the command, and a hand-typed result where it is obvious.
  typedef struct packed {
    cmd_item_t    item;
    logic         typed;
    date_result_t want;
  } directed_row_t;

  localparam int unsigned NumDirected = 25;
  localparam int unsigned NumRandom   = 75;
  localparam int unsigned MaxBigCount = 4;    // full-range day counts in the random part
  localparam int unsigned TailCycles  = 8;

  // Short local names for the codes, keeps the directed table readable.
  localparam cds_pkg::cmd_e    Load  = cds_pkg::CMD_LOAD;
  localparam cds_pkg::cmd_e    Add   = cds_pkg::CMD_ADD;
  localparam cds_pkg::cmd_e    Sub   = cds_pkg::CMD_SUB;
  localparam cds_pkg::cmd_e    Nop   = cds_pkg::CMD_NONE;
  localparam cds_pkg::status_e Ok    = cds_pkg::ST_OK;
  localparam cds_pkg::status_e BadLd = cds_pkg::ST_BAD_LOAD;
  localparam cds_pkg::status_e Lim   = cds_pkg::ST_LIMIT;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [4:0]  load_day_i;
  logic [3:0]  load_month_i;
  logic [13:0] load_year_i;
  logic [15:0] day_count_i;
  logic        done_o;
  logic [4:0]  cur_day_o;
  logic [3:0]  cur_month_o;
  logic [13:0] cur_year_o;
  logic        leap_flag_o;
  logic [1:0]  status_o;

  // Predicted calendar state, mirrors the date register in the block.
  logic [4:0]  cal_day   = 5'd1;
  logic [3:0]  cal_month = 4'd1;
  logic [13:0] cal_year  = cds_pkg::YearReset;

  date_result_t pending_dates[$];
  int unsigned  mismatch_cnt = 0;

  calendar_date_stepper_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .day_count_i  (day_count_i),
    .done_o       (done_o),
    .cur_day_o    (cur_day_o),
    .cur_month_o  (cur_month_o),
    .cur_year_o   (cur_year_o),
    .leap_flag_o  (leap_flag_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop. The slowest legal run (six full-range counts plus ~100
  // items of up to 1500 days, each with its idle gap) takes about 11 ms;
  // the limit is several times that.
  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian rule: every 4th year, except centuries not divisible by 400.
  function automatic logic year_is_leap(input logic [13:0] y);
    int unsigned yi;
    yi = 32'(y);
    return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      default:                                    return year_is_leap(y) ? 5'd29 : 5'd28;
    endcase
  endfunction

  // Move the predicted date one day; 0 when pinned at 0001-01-01 / 9999-12-31.
  function automatic logic step_one_day(input logic forward);
    if (forward) begin
      if (cal_day == 5'd31 && cal_month == 4'd12) begin
        if (cal_year >= cds_pkg::YearMax) return 1'b0;
        cal_year  = cal_year + 14'd1;
        cal_month = 4'd1;
        cal_day   = 5'd1;
      end else if (cal_day >= month_len(cal_month, cal_year)) begin
        cal_month = cal_month + 4'd1;
        cal_day   = 5'd1;
      end else begin
        cal_day = cal_day + 5'd1;
      end
    end else begin
      if (cal_day == 5'd1 && cal_month == 4'd1) begin
        if (cal_year <= cds_pkg::YearMin) return 1'b0;
        cal_year  = cal_year - 14'd1;
        cal_month = 4'd12;
        cal_day   = 5'd31;
      end else if (cal_day == 5'd1) begin
        cal_month = cal_month - 4'd1;
        cal_day   = month_len(cal_month, cal_year);
      end else begin
        cal_day = cal_day - 5'd1;
      end
    end
    return 1'b1;
  endfunction

  // Apply one command to the predicted date and return the result item.
  function automatic date_result_t advance_calendar(input cmd_item_t it);
    cds_pkg::status_e st;
    int unsigned      n;
    st = cds_pkg::ST_OK;
    case (it.cmd)
      cds_pkg::CMD_LOAD: begin
        if (it.year >= cds_pkg::YearMin && it.year <= cds_pkg::YearMax &&
            it.month >= 4'd1 && it.month <= 4'd12 && it.day >= 5'd1 &&
            it.day <= month_len(it.month, it.year)) begin
          cal_day   = it.day;
          cal_month = it.month;
          cal_year  = it.year;
        end else begin
          st = cds_pkg::ST_BAD_LOAD;
        end
      end
      cds_pkg::CMD_ADD, cds_pkg::CMD_SUB: begin
        for (n = 0; n < it.count; n++) begin
          if (!step_one_day(it.cmd == cds_pkg::CMD_ADD)) begin
            st = cds_pkg::ST_LIMIT;
            break;
          end
        end
      end
      default: ;  // unused command: date reported as is
    endcase
    return '{cal_day, cal_month, cal_year, year_is_leap(cal_year), st};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge, acceptance seen on the rising edge
  // ---------------------------------------------------------------------------

  // Idle for the requested gap, present the item, hold it until start & !busy,
  // then queue the result it must produce. typed selects the hand value.
  task automatic issue_command(input cmd_item_t it, input logic typed,
                               input date_result_t typed_res, input int unsigned gap);
    date_result_t predicted;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    command_i    <= it.cmd;
    load_day_i   <= it.day;
    load_month_i <= it.month;
    load_year_i  <= it.year;
    day_count_i  <= it.count;
    do @(posedge clk_i); while (busy);
    predicted = advance_calendar(it);
    pending_dates.push_back(typed ? typed_res : predicted);
  endtask

  // Idle pattern: every third block of 12 items runs back to back.
  function automatic int unsigned pick_gap(input int unsigned idx);
    return (((idx / 12) % 3) == 1) ? 0 : $urandom_range(0, 19);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : check_results
    date_result_t want;
    if (rst_ni && done_o) begin
      if (pending_dates.size() == 0) begin
        note_mismatch($sformatf("unexpected result %0d-%0d-%0d leap %0b status %0d",
                                cur_year_o, cur_month_o, cur_day_o, leap_flag_o, status_o));
      end else begin
        want = pending_dates.pop_front();
        if (cur_day_o !== want.day || cur_month_o !== want.month ||
            cur_year_o !== want.year || leap_flag_o !== want.leap ||
            status_o !== want.status) begin
          note_mismatch($sformatf(
            "exp %0d-%0d-%0d leap %0b status %0d, got %0d-%0d-%0d leap %0b status %0d",
            want.year, want.month, want.day, want.leap, want.status,
            cur_year_o, cur_month_o, cur_day_o, leap_flag_o, status_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed commands
  // ---------------------------------------------------------------------------
  // Typed rows cover the reset date, both range ends and the rejected loads;
  // the rest are checked against the predictor.
  directed_row_t directed_cmds [NumDirected] = '{
    // reset date, unused command and zero counts leave it alone
    '{'{Nop,  5'd0,  4'd0,  14'd0,     16'd0    }, 1'b1, '{5'd1,  4'd1,  14'd2000, 1'b1, Ok}},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'd0    }, 1'b1, '{5'd1,  4'd1,  14'd2000, 1'b1, Ok}},
    '{'{Sub,  5'd31, 4'd15, 14'd16383, 16'd0    }, 1'b1, '{5'd1,  4'd1,  14'd2000, 1'b1, Ok}},
    // upper end: pinned add, step back, land exactly, full-count add
    '{'{Load, 5'd31, 4'd12, 14'd9999,  16'hFFFF }, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0, Ok}},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'd1    }, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0, Lim}},
    '{'{Sub,  5'd0,  4'd0,  14'd0,     16'd1    }, 1'b0, '0},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'd1    }, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0, Ok}},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'hFFFF }, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0, Lim}},
    // lower end
    '{'{Load, 5'd1,  4'd1,  14'd1,     16'd0    }, 1'b1, '{5'd1,  4'd1,  14'd1,    1'b0, Ok}},
    '{'{Sub,  5'd0,  4'd0,  14'd0,     16'd5    }, 1'b1, '{5'd1,  4'd1,  14'd1,    1'b0, Lim}},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'd59   }, 1'b0, '0},
    // leap day rules, then every way a load can be rejected
    '{'{Load, 5'd29, 4'd2,  14'd2000,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, Ok}},
    '{'{Load, 5'd29, 4'd2,  14'd1900,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd0,  4'd5,  14'd2024,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd31, 4'd4,  14'd2024,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd1,  4'd13, 14'd2024,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd1,  4'd0,  14'd2024,  16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd1,  4'd1,  14'd0,     16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd1,  4'd1,  14'd10000, 16'd0    }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    '{'{Load, 5'd31, 4'd15, 14'd16383, 16'hFFFF }, 1'b1, '{5'd29, 4'd2,  14'd2000, 1'b1, BadLd}},
    // long walks across many leap years
    '{'{Load, 5'd29, 4'd2,  14'd2024,  16'd0    }, 1'b0, '0},
    '{'{Add,  5'd31, 4'd15, 14'd16383, 16'd366  }, 1'b0, '0},
    '{'{Sub,  5'd0,  4'd0,  14'd0,     16'hFFFF }, 1'b0, '0},
    '{'{Add,  5'd0,  4'd0,  14'd0,     16'd40000}, 1'b0, '0},
    '{'{Nop,  5'd31, 4'd15, 14'd16383, 16'hFFFF }, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    cmd_item_t   it;
    int unsigned kind;
    int unsigned big_left;
    int unsigned k;

    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = cds_pkg::CMD_NONE;
    load_day_i   = '0;
    load_month_i = '0;
    load_year_i  = '0;
    day_count_i  = '0;
    big_left     = MaxBigCount;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < NumDirected; k++) begin
      issue_command(directed_cmds[k].item, directed_cmds[k].typed,
                    directed_cmds[k].want, pick_gap(k));
    end

    // Random part: mostly add/subtract walks of random length, mixed with valid
    // loads (many near the range ends), junk loads and unused commands.
    for (k = 0; k < NumRandom; k++) begin
      kind     = $urandom_range(0, 99);
      it.day   = 5'($urandom);
      it.month = 4'($urandom);
      it.year  = 14'($urandom);
      it.count = 16'($urandom);
      if (kind < 30) begin
        it.cmd = cds_pkg::CMD_LOAD;
        case ($urandom_range(0, 4))
          0:       it.year = 14'($urandom_range(9998, 9999));
          1:       it.year = 14'($urandom_range(1, 2));
          default: it.year = 14'($urandom_range(1, 9999));
        endcase
        it.month = 4'($urandom_range(1, 12));
        it.day   = 5'($urandom_range(1, month_len(it.month, it.year)));
      end else if (kind < 38) begin
        it.cmd = cds_pkg::CMD_LOAD;   // full-width fields, mostly rejected
      end else if (kind < 43) begin
        it.cmd = cds_pkg::CMD_NONE;
      end else begin
        it.cmd = ($urandom_range(0, 1) != 0) ? cds_pkg::CMD_ADD : cds_pkg::CMD_SUB;
        if (big_left > 0 && $urandom_range(0, 24) == 0) begin
          big_left--;        // keep the full-range count as drawn
        end else if ($urandom_range(0, 5) == 0) begin
          it.count = 16'($urandom_range(0, 1500));
        end else begin
          it.count = 16'($urandom_range(0, 60));
        end
      end
      issue_command(it, 1'b0, '0, pick_gap(k + NumDirected));
    end

    @(negedge clk_i);
    start <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
